>>> sv/qapm_pkg.sv
// ----------------------------------------------------------------------------
// qapm_pkg
// shared types and constants of the attitude pid and quad-x mixer block
// ----------------------------------------------------------------------------
`default_nettype none

package qapm_pkg;

  typedef struct packed {
    logic signed [15:0] roll_target;
    logic signed [15:0] pitch_target;
    logic signed [31:0] yaw_target;
    logic        [15:0] thrust_demand;
    logic signed [15:0] roll_meas;
    logic signed [15:0] pitch_meas;
    logic signed [31:0] yaw_meas;
    logic signed [15:0] roll_rate_meas;
    logic signed [15:0] pitch_rate_meas;
    logic signed [15:0] yaw_rate_meas;
  } in_t;

  typedef struct packed {
    logic [10:0] motor1_pwm;
    logic [10:0] motor2_pwm;
    logic [10:0] motor3_pwm;
    logic [10:0] motor4_pwm;
  } out_t;

  localparam int CFG_IW = 4;
  localparam int CFG_DW = 32;

  localparam logic [CFG_IW-1:0] REG_RP_KP        = 4'd0;
  localparam logic [CFG_IW-1:0] REG_RP_KI        = 4'd1;
  localparam logic [CFG_IW-1:0] REG_RP_KD        = 4'd2;
  localparam logic [CFG_IW-1:0] REG_YAW_OUTER_KP = 4'd3;
  localparam logic [CFG_IW-1:0] REG_YAW_OUTER_KI = 4'd4;
  localparam logic [CFG_IW-1:0] REG_YAW_INNER_KP = 4'd5;
  localparam logic [CFG_IW-1:0] REG_YAW_INNER_KI = 4'd6;
  localparam logic [CFG_IW-1:0] REG_YAW_INNER_KD = 4'd7;

  localparam int MUL_AW = 34;
  localparam int MUL_BW = 32;
  localparam int MUL_PW = 66;
  localparam int FRC_W  = 48;

  localparam logic signed [31:0] DT_Q30     = 32'sd5368709;
  localparam logic signed [31:0] LP_OLD_Q30 = 32'sd1020054733;
  localparam logic signed [31:0] LP_NEW_Q30 = 32'sd53687091;
  localparam logic signed [31:0] MIX_K_Q30  = 32'sd1194108282;
  localparam logic signed [31:0] DERIV_GAIN = 32'sd200;

  localparam int PWM_OFS_Q8  = 176085;
  localparam int PWM_N_OFS   = 63730981;
  localparam int PWM_MIN     = 200;
  localparam int PWM_MAX     = 1800;
  localparam int FORCE_MAX_N = 1600;

  typedef struct packed {
    logic                     start;
    logic signed [MUL_AW-1:0] a;
    logic signed [MUL_BW-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic                     done;
    logic signed [MUL_PW-1:0] p;
  } mul_rsp_t;

  typedef struct packed {
    logic                    start;
    logic signed [FRC_W-1:0] frc;
  } pwm_req_t;

  typedef struct packed {
    logic        done;
    logic [10:0] pwm;
  } pwm_rsp_t;

endpackage

`default_nettype wire

>>> sv/qapm_mul.sv
// ----------------------------------------------------------------------------
// qapm_mul
// bit-serial signed multiplier, one multiplier bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module qapm_mul (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  qapm_pkg::mul_req_t      req_i,
  output qapm_pkg::mul_rsp_t      rsp_o
);
  import qapm_pkg::*;

  localparam int CW = $clog2(MUL_BW);

  logic                   busy_q, done_q;
  logic [CW-1:0]          cnt_q;
  logic signed [MUL_AW:0] hi_q;
  logic [MUL_BW-1:0]      lo_q;
  logic signed [MUL_AW:0] a_q;
  logic signed [MUL_AW:0] addend, sum;
  logic [MUL_AW+MUL_BW:0] full;

  always_comb begin
    addend = '0;
    if (lo_q[0]) begin
      addend = (cnt_q == CW'(MUL_BW - 1)) ? -a_q : a_q;
    end
    sum  = hi_q + addend;
    full = {hi_q, lo_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CW'(1);
        if (cnt_q == CW'(MUL_BW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      a_q  <= {req_i.a[MUL_AW-1], req_i.a};
      hi_q <= '0;
      lo_q <= req_i.b;
    end else if (busy_q) begin
      hi_q <= {sum[MUL_AW], sum[MUL_AW:1]};
      lo_q <= {sum[0], lo_q[MUL_BW-1:1]};
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.p    = full[MUL_PW-1:0];

endmodule

`default_nettype wire

>>> sv/qapm_pwm.sv
// ----------------------------------------------------------------------------
// qapm_pwm
// force to pwm: clamp, serial divide by three, serial square root, clamp
// ----------------------------------------------------------------------------
`default_nettype none

module qapm_pwm #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  qapm_pkg::pwm_req_t req_i,
  output qapm_pkg::pwm_rsp_t rsp_o
);
  import qapm_pkg::*;

  localparam int NW  = 35;
  localparam int YW  = 44;
  localparam int GSH = FRAC_BITS - 8;
  localparam int RSH = (GSH > 0) ? GSH - 1 : 0;
  localparam logic [FRC_W-1:0] RND = (GSH > 0) ? (48'd1 << RSH) : 48'd0;
  localparam logic signed [FRC_W-1:0] FMAX = 48'(FORCE_MAX_N) <<< FRAC_BITS;

  typedef enum logic [2:0] {
    P_IDLE, P_PREP, P_DIV, P_Y1, P_Y2, P_Y3, P_SQRT, P_FIN
  } pstate_e;

  pstate_e                 state_q;
  logic signed [FRC_W-1:0] frc_q;
  logic [NW-1:0]           n_q, dn_q, q_q;
  logic [1:0]              rem_q;
  logic [5:0]              cnt_q;
  logic [YW-1:0]           y_q, r_q, bit_q;
  logic                    done_q;
  logic [10:0]             pwm_q;

  logic [FRC_W-1:0]        fc, g;
  logic [2:0]              dt;
  logic                    dge;
  logic [YW:0]             st;
  logic signed [YW+1:0]    pv, ph;

  always_comb begin
    if (frc_q <= 0) begin
      fc = '0;
    end else if (frc_q > FMAX) begin
      fc = FMAX;
    end else begin
      fc = frc_q;
    end
    g   = (fc + RND) >> GSH;
    dt  = {rem_q, dn_q[NW-1]};
    dge = (dt >= 3'd3);
    st  = {1'b0, r_q} + {1'b0, bit_q};
    pv  = $signed({2'b00, r_q}) - 46'(PWM_OFS_Q8);
    ph  = pv >>> 8;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= P_IDLE;
      done_q  <= 1'b0;
      pwm_q   <= 11'(PWM_MIN);
      frc_q   <= '0;
      n_q     <= '0;
      dn_q    <= '0;
      q_q     <= '0;
      rem_q   <= '0;
      cnt_q   <= '0;
      y_q     <= '0;
      r_q     <= '0;
      bit_q   <= '0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        P_IDLE: begin
          if (req_i.start) begin
            frc_q   <= req_i.frc;
            state_q <= P_PREP;
          end
        end
        P_PREP: begin
          n_q     <= (NW'(g) << 15) + NW'(PWM_N_OFS);
          dn_q    <= (NW'(g) << 15) + NW'(PWM_N_OFS);
          q_q     <= '0;
          rem_q   <= '0;
          cnt_q   <= '0;
          state_q <= P_DIV;
        end
        P_DIV: begin
          rem_q <= dge ? 2'(dt - 3'd3) : dt[1:0];
          q_q   <= {q_q[NW-2:0], dge};
          dn_q  <= {dn_q[NW-2:0], 1'b0};
          cnt_q <= cnt_q + 6'd1;
          if (cnt_q == 6'(NW - 1)) begin
            state_q <= P_Y1;
          end
        end
        P_Y1: begin
          y_q     <= (YW'(n_q) << 9) + (YW'(n_q) << 8);
          state_q <= P_Y2;
        end
        P_Y2: begin
          y_q     <= y_q + (YW'(n_q) << 6);
          state_q <= P_Y3;
        end
        P_Y3: begin
          y_q     <= y_q + YW'(n_q) + YW'(q_q);
          r_q     <= '0;
          bit_q   <= YW'(1) << (YW - 2);
          state_q <= P_SQRT;
        end
        P_SQRT: begin
          if ({1'b0, y_q} >= st) begin
            y_q <= y_q - st[YW-1:0];
            r_q <= (r_q >> 1) + bit_q;
          end else begin
            r_q <= r_q >> 1;
          end
          bit_q <= bit_q >> 2;
          if (bit_q[0]) begin
            state_q <= P_FIN;
          end
        end
        P_FIN: begin
          if (pv < 46'sd51200) begin
            pwm_q <= 11'(PWM_MIN);
          end else if (ph > 46'(PWM_MAX)) begin
            pwm_q <= 11'(PWM_MAX);
          end else begin
            pwm_q <= ph[10:0];
          end
          done_q  <= 1'b1;
          state_q <= P_IDLE;
        end
        default: state_q <= P_IDLE;
      endcase
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.pwm  = pwm_q;

endmodule

`default_nettype wire

>>> sv/quadrotor_attitude_pid_mixer.sv
// ----------------------------------------------------------------------------
// quadrotor_attitude_pid_mixer
// roll/pitch pid, yaw cascade pid, quad-x mixer and square-root pwm law
//
// one request on the input channel (valid/ready) carries targets, thrust and
// measured angles and rates; one result with four motor pwm values follows.
// gains are to be written through the plain write port only while the block
// is idle; the block itself does not enforce this. a request is taken only
// when the sequencer is idle; it then runs 22 multiplies on one bit-serial
// multiplier and four passes of the pwm unit (divide by three and square
// root) before the result is ready. the result sits in an output register;
// the next request is taken while it waits, and the sequencer holds at its
// end until that register is free.
// reset clears all integrators and filter state and loads the default gains.
// ----------------------------------------------------------------------------
`default_nettype none

module quadrotor_attitude_pid_mixer #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  qapm_pkg::in_t                      in_data_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output qapm_pkg::out_t                     out_data_o,
  input  wire logic                          cfg_we_i,
  input  wire logic [qapm_pkg::CFG_IW-1:0]   cfg_idx_i,
  input  wire logic [qapm_pkg::CFG_DW-1:0]   cfg_wdata_i
);
  import qapm_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_MUL, S_PWM, S_OUT} state_e;

  typedef enum logic [4:0] {
    ST_R_DT, ST_R_KP, ST_R_KI, ST_R_KD,
    ST_P_DT, ST_P_KP, ST_P_KI, ST_P_KD,
    ST_YA_DT, ST_YA_KP, ST_YA_KI,
    ST_YR_DT, ST_YR_RAW, ST_YR_LPO, ST_YR_LPN, ST_YR_KP, ST_YR_KI, ST_YR_KD,
    ST_MIX1, ST_MIX2, ST_MIX3, ST_MIX4
  } step_e;

  localparam logic signed [MUL_PW-1:0] LIM = 66'sd2 <<< FRAC_BITS;

  function automatic logic signed [47:0] cvt(input logic signed [47:0] x, input int frm);
    if (FRAC_BITS >= frm) begin
      return x <<< (FRAC_BITS - frm);
    end
    return (x + (48'sd1 <<< (frm - FRAC_BITS - 1))) >>> (frm - FRAC_BITS);
  endfunction

  function automatic logic signed [31:0] sat48(input logic signed [47:0] x);
    if (x > 48'sd2147483647) begin
      return 32'sh7fffffff;
    end
    if (x < -48'sd2147483648) begin
      return 32'sh80000000;
    end
    return x[31:0];
  endfunction

  function automatic logic signed [31:0] satp(input logic signed [MUL_PW-1:0] x);
    if (x > 66'sd2147483647) begin
      return 32'sh7fffffff;
    end
    if (x < -66'sd2147483648) begin
      return 32'sh80000000;
    end
    return x[31:0];
  endfunction

  function automatic logic signed [MUL_PW-1:0] rnd30(input logic signed [MUL_PW-1:0] x);
    return (x + 66'sd536870912) >>> 30;
  endfunction

  function automatic logic signed [31:0] integ(input logic signed [31:0] iv,
                                               input logic signed [MUL_PW-1:0] p);
    logic signed [MUL_PW-1:0] v;
    v = MUL_PW'(iv) + rnd30(p);
    if (v > LIM) begin
      v = LIM;
    end
    if (v < -LIM) begin
      v = -LIM;
    end
    return v[31:0];
  endfunction

  function automatic logic signed [MUL_AW-1:0] ext(input logic signed [31:0] x);
    return MUL_AW'(x);
  endfunction

  state_e             state_q;
  step_e              step_q;
  in_t                in_q;
  logic               mul_start_q, pwm_start_q;
  logic signed [31:0] rp_kp_q, rp_ki_q, rp_kd_q, yo_kp_q, yo_ki_q, yi_kp_q, yi_ki_q, yi_kd_q;
  logic signed [31:0] roll_integ_q, pitch_integ_q, yaw_angle_integ_q, yaw_rate_integ_q;
  logic signed [31:0] last_rate_err_q, last_dterm_q;
  logic signed [33:0] sum_q;
  logic signed [31:0] tr_q, tp_q, ty_q, rate_err_q, raw_q;
  logic signed [MUL_PW-1:0] prod_q;
  logic signed [FRC_W-1:0]  frc_q;
  logic [10:0]        pwm1_q, pwm2_q, pwm3_q, pwm4_q;
  logic               out_valid_q;
  out_t               out_q;

  mul_req_t           mul_req;
  mul_rsp_t           mul_rsp;
  pwm_req_t           pwm_req;
  pwm_rsp_t           pwm_rsp;

  logic signed [31:0] err_r, err_p, err_y, rr, pr, yr, g, filt;
  logic signed [47:0] th, ymix;
  logic signed [MUL_AW-1:0] a_op;
  logic signed [MUL_BW-1:0] b_op;

  always_comb begin
    err_r = sat48(cvt(48'(in_q.roll_target), 12) + cvt(48'(in_q.roll_meas), 12));
    err_p = sat48(cvt(48'(in_q.pitch_target), 12) - cvt(48'(in_q.pitch_meas), 12));
    err_y = sat48(cvt(48'(in_q.yaw_meas) - 48'(in_q.yaw_target), 16));
    rr    = sat48(cvt(48'(in_q.roll_rate_meas), 12));
    pr    = sat48(cvt(48'(in_q.pitch_rate_meas), 12));
    yr    = sat48(cvt(48'(in_q.yaw_rate_meas), 12));
    th    = cvt($signed(48'(in_q.thrust_demand)), 8);
    g     = satp((mul_rsp.p + 66'sd32768) >>> 16);
    filt  = satp(rnd30(prod_q + mul_rsp.p));
    if (step_q == ST_MIX1 || step_q == ST_MIX3) begin
      ymix = 48'(ty_q) + th + 48'sd2;
    end else begin
      ymix = th - 48'(ty_q) + 48'sd2;
    end
  end

  always_comb begin
    a_op = '0;
    b_op = DT_Q30;
    unique case (step_q)
      ST_R_DT:   begin a_op = ext(err_r);             b_op = DT_Q30;     end
      ST_R_KP:   begin a_op = ext(err_r);             b_op = rp_kp_q;    end
      ST_R_KI:   begin a_op = ext(roll_integ_q);      b_op = rp_ki_q;    end
      ST_R_KD:   begin a_op = -ext(rr);               b_op = rp_kd_q;    end
      ST_P_DT:   begin a_op = ext(err_p);             b_op = DT_Q30;     end
      ST_P_KP:   begin a_op = ext(err_p);             b_op = rp_kp_q;    end
      ST_P_KI:   begin a_op = ext(pitch_integ_q);     b_op = rp_ki_q;    end
      ST_P_KD:   begin a_op = ext(pr);                b_op = rp_kd_q;    end
      ST_YA_DT:  begin a_op = ext(err_y);             b_op = DT_Q30;     end
      ST_YA_KP:  begin a_op = ext(err_y);             b_op = yo_kp_q;    end
      ST_YA_KI:  begin a_op = ext(yaw_angle_integ_q); b_op = yo_ki_q;    end
      ST_YR_DT:  begin a_op = ext(rate_err_q);        b_op = DT_Q30;     end
      ST_YR_RAW: begin
        a_op = ext(rate_err_q) - ext(last_rate_err_q);
        b_op = DERIV_GAIN;
      end
      ST_YR_LPO: begin a_op = ext(last_dterm_q);      b_op = LP_OLD_Q30; end
      ST_YR_LPN: begin a_op = ext(raw_q);             b_op = LP_NEW_Q30; end
      ST_YR_KP:  begin a_op = ext(rate_err_q);        b_op = yi_kp_q;    end
      ST_YR_KI:  begin a_op = ext(yaw_rate_integ_q);  b_op = yi_ki_q;    end
      ST_YR_KD:  begin a_op = ext(last_dterm_q);      b_op = yi_kd_q;    end
      ST_MIX1:   begin a_op = -ext(tr_q) - ext(tp_q); b_op = MIX_K_Q30;  end
      ST_MIX2:   begin a_op = ext(tp_q) - ext(tr_q);  b_op = MIX_K_Q30;  end
      ST_MIX3:   begin a_op = ext(tr_q) + ext(tp_q);  b_op = MIX_K_Q30;  end
      ST_MIX4:   begin a_op = ext(tr_q) - ext(tp_q);  b_op = MIX_K_Q30;  end
      default:   begin a_op = '0;                     b_op = DT_Q30;     end
    endcase
  end

  assign mul_req.start = mul_start_q;
  assign mul_req.a     = a_op;
  assign mul_req.b     = b_op;
  assign pwm_req.start = pwm_start_q;
  assign pwm_req.frc   = frc_q;

  qapm_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .rsp_o  (mul_rsp)
  );

  qapm_pwm #(.FRAC_BITS(FRAC_BITS)) u_pwm (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (pwm_req),
    .rsp_o  (pwm_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q           <= S_IDLE;
      step_q            <= ST_R_DT;
      in_q              <= '0;
      mul_start_q       <= 1'b0;
      pwm_start_q       <= 1'b0;
      rp_kp_q           <= 32'sd196608;
      rp_ki_q           <= 32'sd0;
      rp_kd_q           <= 32'sd32768;
      yo_kp_q           <= 32'sd9830400;
      yo_ki_q           <= 32'sd0;
      yi_kp_q           <= 32'sd196608;
      yi_ki_q           <= 32'sd0;
      yi_kd_q           <= 32'sd0;
      roll_integ_q      <= '0;
      pitch_integ_q     <= '0;
      yaw_angle_integ_q <= '0;
      yaw_rate_integ_q  <= '0;
      last_rate_err_q   <= '0;
      last_dterm_q      <= '0;
      sum_q             <= '0;
      tr_q              <= '0;
      tp_q              <= '0;
      ty_q              <= '0;
      rate_err_q        <= '0;
      raw_q             <= '0;
      prod_q            <= '0;
      frc_q             <= '0;
      pwm1_q            <= '0;
      pwm2_q            <= '0;
      pwm3_q            <= '0;
      pwm4_q            <= '0;
      out_valid_q       <= 1'b0;
      out_q             <= '0;
    end else begin
      mul_start_q <= 1'b0;
      pwm_start_q <= 1'b0;

      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_RP_KP:        rp_kp_q <= cfg_wdata_i;
          REG_RP_KI:        rp_ki_q <= cfg_wdata_i;
          REG_RP_KD:        rp_kd_q <= cfg_wdata_i;
          REG_YAW_OUTER_KP: yo_kp_q <= cfg_wdata_i;
          REG_YAW_OUTER_KI: yo_ki_q <= cfg_wdata_i;
          REG_YAW_INNER_KP: yi_kp_q <= cfg_wdata_i;
          REG_YAW_INNER_KI: yi_ki_q <= cfg_wdata_i;
          REG_YAW_INNER_KD: yi_kd_q <= cfg_wdata_i;
          default: ;
        endcase
      end

      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            in_q        <= in_data_i;
            step_q      <= ST_R_DT;
            mul_start_q <= 1'b1;
            state_q     <= S_MUL;
          end
        end
        S_MUL: begin
          if (mul_rsp.done) begin
            unique case (step_q)
              ST_R_DT:  roll_integ_q      <= integ(roll_integ_q, mul_rsp.p);
              ST_P_DT:  pitch_integ_q     <= integ(pitch_integ_q, mul_rsp.p);
              ST_YA_DT: yaw_angle_integ_q <= integ(yaw_angle_integ_q, mul_rsp.p);
              ST_YR_DT: yaw_rate_integ_q  <= integ(yaw_rate_integ_q, mul_rsp.p);
              ST_R_KP, ST_P_KP, ST_YA_KP, ST_YR_KP: sum_q <= 34'(g);
              ST_R_KI, ST_P_KI, ST_YR_KI:           sum_q <= sum_q + 34'(g);
              ST_R_KD:  tr_q <= sat48(48'(sum_q + 34'(g)));
              ST_P_KD:  tp_q <= sat48(48'(sum_q + 34'(g)));
              ST_YR_KD: ty_q <= sat48(48'(sum_q + 34'(g)));
              ST_YA_KI: rate_err_q <= sat48(48'(sat48(48'(sum_q + 34'(g)))) + 48'(yr));
              ST_YR_RAW: raw_q <= satp(mul_rsp.p);
              ST_YR_LPO: prod_q <= mul_rsp.p;
              ST_YR_LPN: begin
                last_dterm_q    <= filt;
                last_rate_err_q <= rate_err_q;
              end
              ST_MIX1, ST_MIX2, ST_MIX3, ST_MIX4: begin
                frc_q <= 48'(rnd30(mul_rsp.p)) + (ymix >>> 2);
              end
              default: ;
            endcase
            if (step_q == ST_MIX1 || step_q == ST_MIX2 ||
                step_q == ST_MIX3 || step_q == ST_MIX4) begin
              pwm_start_q <= 1'b1;
              state_q     <= S_PWM;
            end else begin
              step_q      <= step_e'(step_q + 5'd1);
              mul_start_q <= 1'b1;
            end
          end
        end
        S_PWM: begin
          if (pwm_rsp.done) begin
            priority case (step_q)
              ST_MIX1: pwm1_q <= pwm_rsp.pwm;
              ST_MIX2: pwm2_q <= pwm_rsp.pwm;
              ST_MIX3: pwm3_q <= pwm_rsp.pwm;
              default: pwm4_q <= pwm_rsp.pwm;
            endcase
            if (step_q == ST_MIX4) begin
              state_q <= S_OUT;
            end else begin
              step_q      <= step_e'(step_q + 5'd1);
              mul_start_q <= 1'b1;
              state_q     <= S_MUL;
            end
          end
        end
        S_OUT: begin
          if (!out_valid_q || out_ready_i) begin
            out_q.motor1_pwm <= pwm1_q;
            out_q.motor2_pwm <= pwm2_q;
            out_q.motor3_pwm <= pwm3_q;
            out_q.motor4_pwm <= pwm4_q;
            out_valid_q      <= 1'b1;
            state_q          <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == S_MUL && step_q == ST_R_DT))
    else $error("accepted request did not start the sequencer");

  a_mul_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_rsp.done |-> (state_q == S_MUL))
    else $error("multiplier finished outside multiply state");

  a_pwm_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pwm_rsp.done |-> (state_q == S_PWM))
    else $error("pwm unit finished outside pwm state");

  a_pwm_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.motor1_pwm >= 11'd200 && out_data_o.motor1_pwm <= 11'd1800 &&
                     out_data_o.motor4_pwm >= 11'd200 && out_data_o.motor4_pwm <= 11'd1800))
    else $error("pwm result out of range");

endmodule

`default_nettype wire
